// File: rtl/rsi_pkg.sv
// Shared types and constants of the ray and sphere intersection pipeline.
// Used by rsi_sqrt and ray_sphere_intersection; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rsi_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned RAD_W      = 64;
  localparam int unsigned ROOT_W     = RAD_W / 2;
  localparam int unsigned SQRT_STEPS = ROOT_W;
  localparam int unsigned UNIT_W     = 31;
  localparam int unsigned UNIT_FRAC  = 30;
  localparam int unsigned DIV_STEPS  = UNIT_W;
  localparam int unsigned CFG_IDX_W  = 8;

  localparam logic [30:0] RADIUS_ONE = 31'd65536;
  localparam logic [61:0] RSQ_ONE    = 62'h1_0000_0000;
  localparam logic [63:0] ROUND_HALF = 64'h2000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS = 8'd0,
    REG_ENABLE = 8'd1
  } cfg_reg_e;

  typedef logic [2:0][WORD_W-1:0] vec3_t;
  typedef logic [2:0][UNIT_W-1:0] unit3_t;

  typedef struct packed {
    vec3_t       o;
    vec3_t       a;
    logic [2:0]  neg;
    logic        kill;
    logic [63:0] osq;
  } sq1_side_t;

  typedef struct packed {
    vec3_t       o;
    logic [2:0]  neg;
    logic        kill;
    logic [63:0] osq;
    logic [31:0] len;
  } div_side_t;

  typedef struct packed {
    vec3_t       o;
    unit3_t      q;
    logic [2:0]  neg;
    logic        kill;
    logic [31:0] hm;
    logic        hneg;
  } sq2_side_t;

endpackage

`default_nettype wire

// File: rtl/rsi_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// A side word travels alongside each radicand. Depends on rsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsi_sqrt #(
  parameter int unsigned SideW = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        ce_i,
  input  logic                        valid_i,
  input  logic [rsi_pkg::RAD_W-1:0]   rad_i,
  input  logic [SideW-1:0]            side_i,
  output logic                        valid_o,
  output logic [rsi_pkg::ROOT_W-1:0]  root_o,
  output logic [SideW-1:0]            side_o
);
  import rsi_pkg::*;

  localparam int unsigned RemW = ROOT_W + 2;
  localparam int unsigned CurW = ROOT_W + 4;

  logic [SQRT_STEPS-1:0] valid_q;
  logic [RAD_W-1:0]      rad_q  [SQRT_STEPS];
  logic [RemW-1:0]       rem_q  [SQRT_STEPS];
  logic [ROOT_W-1:0]     root_q [SQRT_STEPS];
  logic [SideW-1:0]      side_q [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic              v_in;
    logic [RAD_W-1:0]  rad_in;
    logic [RemW-1:0]   rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SideW-1:0]  side_in;
    logic [CurW-1:0]   cur;
    logic [CurW-1:0]   trial;
    logic [CurW-1:0]   diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign cur   = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign diff  = cur - trial;
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (ce_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        rad_q[k]  <= rad_in << 2;
        rem_q[k]  <= ge ? diff[RemW-1:0] : cur[RemW-1:0];
        root_q[k] <= {root_in[ROOT_W-2:0], ge};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[SQRT_STEPS-1];
  assign root_o  = root_q[SQRT_STEPS-1];
  assign side_o  = side_q[SQRT_STEPS-1];

endmodule

`default_nettype wire

// File: rtl/ray_sphere_intersection.sv
// Ray against origin-centered sphere: normalize, solve, pick the root, give the hit point.
// Depends on rsi_pkg and rsi_sqrt.
//
//  Channel   Dir  Handshake                      Payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  origin x,y,z, dir x,y,z (Q16.16)
//  m_axis    out  m_axis_tvalid / m_axis_tready  hit x,y,z (Q16.16), tuser = hit
//  cfg       in   cfg_valid_i / cfg_ready_o      register index, write data
//
// One request enters every cycle while s_axis_tready is high.
// The pipeline includes the two 32-stage square roots and the 31-stage divider.
// Reset restores radius 1.0 and the sphere enabled, and empties the pipeline.
// When the output register holds a result that is not taken, every stage holds.
`timescale 1ns / 1ps
`default_nettype none

module ray_sphere_intersection (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z from the lowest bit up
  input  logic [191:0]                  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // hit_x, hit_y, hit_z from the lowest bit up
  output logic [95:0]                   m_axis_tdata,
  // hit
  output logic [0:0]                    m_axis_tuser,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rsi_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import rsi_pkg::*;

  logic ce;

  // Configuration registers.
  logic [30:0] radius_q;
  logic        enable_q;
  logic [61:0] rsq_q;
  logic [30:0] r_eff;
  logic [61:0] rsq_d;

  assign cfg_ready_o = 1'b1;
  assign r_eff = (radius_q == '0) ? RADIUS_ONE : radius_q;
  assign rsq_d = r_eff * r_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_ONE;
      enable_q <= 1'b1;
      rsq_q    <= RSQ_ONE;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_RADIUS: radius_q <= cfg_data_i[30:0];
          REG_ENABLE: enable_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      rsq_q <= rsq_d;
    end
  end

  // Stage 1: unpack, magnitudes of the direction.
  vec3_t      in_o, in_d, a1_d;
  logic [2:0] neg1_d;
  logic       kill1_d;
  logic       v1_q, kill1_q;
  vec3_t      o1_q, a1_q;
  logic [2:0] neg1_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_o[i]   = s_axis_tdata[32*i +: 32];
      in_d[i]   = s_axis_tdata[96+32*i +: 32];
      neg1_d[i] = in_d[i][31];
      a1_d[i]   = in_d[i][31] ? (~in_d[i] + 32'd1) : in_d[i];
    end
    kill1_d = !enable_q || (a1_d == '0);
  end

  // Stage 2: normalizing shift from the largest magnitude, magnitudes of the origin.
  logic [31:0] m01, mx;
  logic [4:0]  sh2_d;
  vec3_t       om2_d;
  logic        v2_q, kill2_q;
  vec3_t       o2_q, a2_q, om2_q;
  logic [2:0]  neg2_q;
  logic [4:0]  sh2_q;

  always_comb begin
    m01   = (a1_q[0] > a1_q[1]) ? a1_q[0] : a1_q[1];
    mx    = (m01 > a1_q[2]) ? m01 : a1_q[2];
    sh2_d = '0;
    for (int k = 0; k < 30; k++) begin
      if (mx[k]) begin
        sh2_d = 5'(30 - k);
      end
    end
    if (mx[31] || mx[30]) begin
      sh2_d = '0;
    end
    for (int i = 0; i < 3; i++) begin
      om2_d[i] = o1_q[i][31] ? (~o1_q[i] + 32'd1) : o1_q[i];
    end
  end

  // Stage 3: shifted magnitudes, squares of the origin.
  vec3_t       as3_d;
  logic [63:0] osqp3_d [3];
  logic        v3_q, kill3_q;
  vec3_t       o3_q, as3_q;
  logic [2:0]  neg3_q;
  logic [63:0] osqp3_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      as3_d[i]   = a2_q[i] << sh2_q;
      osqp3_d[i] = om2_q[i] * om2_q[i];
    end
  end

  // Stage 4: squares of the direction, |O|^2.
  logic [63:0] sq4_d [3];
  logic [63:0] osq4_d;
  logic        v4_q, kill4_q;
  vec3_t       o4_q, as4_q;
  logic [2:0]  neg4_q;
  logic [63:0] sq4_q [3];
  logic [63:0] osq4_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq4_d[i] = as3_q[i] * as3_q[i];
    end
    osq4_d = osqp3_q[0] + osqp3_q[1] + osqp3_q[2];
  end

  // Stage 5: squared length.
  logic [63:0] len5_d;
  logic        v5_q;
  logic [63:0] len5_q;
  sq1_side_t   side5_q;

  assign len5_d = sq4_q[0] + sq4_q[1] + sq4_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (ce) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      o1_q    <= in_o;
      a1_q    <= a1_d;
      neg1_q  <= neg1_d;
      kill1_q <= kill1_d;
      o2_q    <= o1_q;
      a2_q    <= a1_q;
      om2_q   <= om2_d;
      neg2_q  <= neg1_q;
      kill2_q <= kill1_q;
      sh2_q   <= sh2_d;
      o3_q    <= o2_q;
      as3_q   <= as3_d;
      osqp3_q <= osqp3_d;
      neg3_q  <= neg2_q;
      kill3_q <= kill2_q;
      o4_q    <= o3_q;
      as4_q   <= as3_q;
      sq4_q   <= sq4_d;
      osq4_q  <= osq4_d;
      neg4_q  <= neg3_q;
      kill4_q <= kill3_q;
      len5_q       <= len5_d;
      side5_q.o    <= o4_q;
      side5_q.a    <= as4_q;
      side5_q.neg  <= neg4_q;
      side5_q.kill <= kill4_q;
      side5_q.osq  <= osq4_q;
    end
  end

  // Length of the shifted direction.
  logic        sq1_v;
  logic [31:0] sq1_root;
  sq1_side_t   sq1_side;

  rsi_sqrt #(
    .SideW ($bits(sq1_side_t))
  ) u_len_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ce_i    (ce),
    .valid_i (v5_q),
    .rad_i   (len5_q),
    .side_i  (side5_q),
    .valid_o (sq1_v),
    .root_o  (sq1_root),
    .side_o  (sq1_side)
  );

  // Stage 6: rounded dividends.
  logic [61:0] n6_d [3];
  logic        v6_q;
  vec3_t       rem6_q;
  unit3_t      rest6_q;
  div_side_t   side6_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n6_d[i] = {sq1_side.a[i], 30'd0} + {31'd0, sq1_root[31:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (ce) begin
      v6_q <= sq1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        rem6_q[i]  <= {1'b0, n6_d[i][61:31]};
        rest6_q[i] <= n6_d[i][30:0];
      end
      side6_q.o    <= sq1_side.o;
      side6_q.neg  <= sq1_side.neg;
      side6_q.kill <= sq1_side.kill;
      side6_q.osq  <= sq1_side.osq;
      side6_q.len  <= sq1_root;
    end
  end

  // Restoring divider, one quotient bit per stage in each of three lanes.
  logic [DIV_STEPS-1:0] dv_q;
  vec3_t                drem_q  [DIV_STEPS];
  unit3_t               drest_q [DIV_STEPS];
  unit3_t               dquo_q  [DIV_STEPS];
  div_side_t            dside_q [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic      v_in;
    vec3_t     rem_in;
    unit3_t    rest_in;
    unit3_t    quo_in;
    div_side_t side_in;
    vec3_t     rem_d;
    unit3_t    quo_d;

    if (j == 0) begin : g_first
      assign v_in    = v6_q;
      assign rem_in  = rem6_q;
      assign rest_in = rest6_q;
      assign quo_in  = '0;
      assign side_in = side6_q;
    end else begin : g_next
      assign v_in    = dv_q[j-1];
      assign rem_in  = drem_q[j-1];
      assign rest_in = drest_q[j-1];
      assign quo_in  = dquo_q[j-1];
      assign side_in = dside_q[j-1];
    end

    always_comb begin
      logic [32:0] cur;
      logic [32:0] diff;
      for (int i = 0; i < 3; i++) begin
        cur  = {rem_in[i], rest_in[i][UNIT_W-1]};
        diff = cur - {1'b0, side_in.len};
        if (cur >= {1'b0, side_in.len}) begin
          rem_d[i] = diff[31:0];
          quo_d[i] = {quo_in[i][UNIT_W-2:0], 1'b1};
        end else begin
          rem_d[i] = cur[31:0];
          quo_d[i] = {quo_in[i][UNIT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else if (ce) begin
        dv_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce) begin
        drem_q[j] <= rem_d;
        for (int i = 0; i < 3; i++) begin
          drest_q[j][i] <= rest_in[i] << 1;
        end
        dquo_q[j]  <= quo_d;
        dside_q[j] <= side_in;
      end
    end
  end

  // Stage 7: signed unit vector times origin.
  logic signed [31:0] u7 [3];
  logic signed [63:0] p7_d [3];
  logic               v7_q, kill7_q;
  vec3_t              o7_q;
  unit3_t             q7_q;
  logic [2:0]         neg7_q;
  logic [63:0]        osq7_q;
  logic signed [63:0] p7_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u7[i]   = dside_q[DIV_STEPS-1].neg[i] ? -$signed({1'b0, dquo_q[DIV_STEPS-1][i]})
                                           : $signed({1'b0, dquo_q[DIV_STEPS-1][i]});
      p7_d[i] = $signed(dside_q[DIV_STEPS-1].o[i]) * u7[i];
    end
  end

  // Stage 8: h = O.u in Q18.46.
  logic signed [63:0] h8_d;
  logic               v8_q, kill8_q;
  vec3_t              o8_q;
  unit3_t             q8_q;
  logic [2:0]         neg8_q;
  logic [63:0]        osq8_q;
  logic signed [63:0] h8_q;

  assign h8_d = p7_q[0] + p7_q[1] + p7_q[2];

  // Stage 9: rounded |h|, offset term c = ||O|^2 - R^2|.
  logic [63:0] habs9, hr9, osq_ext, rsq_ext;
  logic [31:0] hm9_d;
  logic        ge9_d;
  logic [63:0] c9_d;
  logic        v9_q, kill9_q, hneg9_q, ge9_q;
  vec3_t       o9_q;
  unit3_t      q9_q;
  logic [2:0]  neg9_q;
  logic [31:0] hm9_q;
  logic [63:0] c9_q;

  always_comb begin
    habs9   = h8_q[63] ? (~h8_q + 64'd1) : h8_q;
    hr9     = habs9 + ROUND_HALF;
    hm9_d   = (hr9[63:62] != 2'b00) ? 32'hFFFF_FFFF : hr9[61:30];
    osq_ext = osq8_q;
    rsq_ext = {2'b00, rsq_q};
    ge9_d   = (osq_ext >= rsq_ext);
    c9_d    = ge9_d ? (osq_ext - rsq_ext) : (rsq_ext - osq_ext);
  end

  // Stage 10: h squared.
  logic [63:0] hh10_d;
  logic        v10_q, kill10_q, hneg10_q, ge10_q;
  vec3_t       o10_q;
  unit3_t      q10_q;
  logic [2:0]  neg10_q;
  logic [31:0] hm10_q;
  logic [63:0] c10_q, hh10_q;

  assign hh10_d = hm9_q * hm9_q;

  // Stage 11: discriminant.
  logic [64:0] sum11;
  logic [63:0] disc11_d;
  logic        kill11_d;
  logic        v11_q;
  logic [63:0] disc11_q;
  sq2_side_t   side11_q;

  always_comb begin
    sum11    = {1'b0, hh10_q} + {1'b0, c10_q};
    kill11_d = kill10_q;
    if (ge10_q) begin
      disc11_d = hh10_q - c10_q;
      if (hh10_q < c10_q) begin
        kill11_d = 1'b1;
      end
    end else begin
      disc11_d = sum11[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum11[63:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
    end else if (ce) begin
      v7_q  <= dv_q[DIV_STEPS-1];
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
      v11_q <= v10_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      o7_q     <= dside_q[DIV_STEPS-1].o;
      q7_q     <= dquo_q[DIV_STEPS-1];
      neg7_q   <= dside_q[DIV_STEPS-1].neg;
      kill7_q  <= dside_q[DIV_STEPS-1].kill;
      osq7_q   <= dside_q[DIV_STEPS-1].osq;
      p7_q     <= p7_d;
      o8_q     <= o7_q;
      q8_q     <= q7_q;
      neg8_q   <= neg7_q;
      kill8_q  <= kill7_q;
      osq8_q   <= osq7_q;
      h8_q     <= h8_d;
      o9_q     <= o8_q;
      q9_q     <= q8_q;
      neg9_q   <= neg8_q;
      kill9_q  <= kill8_q;
      hm9_q    <= hm9_d;
      hneg9_q  <= h8_q[63];
      ge9_q    <= ge9_d;
      c9_q     <= c9_d;
      o10_q    <= o9_q;
      q10_q    <= q9_q;
      neg10_q  <= neg9_q;
      kill10_q <= kill9_q;
      hm10_q   <= hm9_q;
      hneg10_q <= hneg9_q;
      ge10_q   <= ge9_q;
      c10_q    <= c9_q;
      hh10_q   <= hh10_d;
      disc11_q      <= disc11_d;
      side11_q.o    <= o10_q;
      side11_q.q    <= q10_q;
      side11_q.neg  <= neg10_q;
      side11_q.kill <= kill11_d;
      side11_q.hm   <= hm10_q;
      side11_q.hneg <= hneg10_q;
    end
  end

  // Square root of the discriminant.
  logic        sq2_v;
  logic [31:0] sq2_root;
  sq2_side_t   sq2_side;

  rsi_sqrt #(
    .SideW ($bits(sq2_side_t))
  ) u_disc_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ce_i    (ce),
    .valid_i (v11_q),
    .rad_i   (disc11_q),
    .side_i  (side11_q),
    .valid_o (sq2_v),
    .root_o  (sq2_root),
    .side_o  (sq2_side)
  );

  // Stage 12: nearest root ahead of the origin.
  logic signed [34:0] hs12, rt12, t1_12, t2_12;
  logic [32:0]        t12_d;
  logic               kill12_d;
  logic               v12_q, kill12_q;
  vec3_t              o12_q;
  unit3_t             q12_q;
  logic [2:0]         neg12_q;
  logic [32:0]        t12_q;

  always_comb begin
    hs12     = sq2_side.hneg ? -$signed({3'b000, sq2_side.hm}) : $signed({3'b000, sq2_side.hm});
    rt12     = $signed({3'b000, sq2_root});
    t1_12    = -hs12 - rt12;
    t2_12    = -hs12 + rt12;
    kill12_d = sq2_side.kill;
    t12_d    = '0;
    if (t1_12 > 35'sd1) begin
      t12_d = t1_12[32:0];
    end else if (t2_12 > 35'sd1) begin
      t12_d = t2_12[32:0];
    end else begin
      kill12_d = 1'b1;
    end
  end

  // Stage 13: t times each unit component.
  logic [63:0] prod13_d [3];
  logic        v13_q, kill13_q;
  vec3_t       o13_q;
  logic [2:0]  neg13_q;
  logic [63:0] prod13_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod13_d[i] = t12_q * q12_q[i];
    end
  end

  // Stage 14: hit point, saturated, into the output register.
  logic [63:0]        pr14 [3];
  logic signed [35:0] step14 [3];
  logic signed [35:0] sum14 [3];
  vec3_t              hit14_d;
  logic               out_v_q, out_hit_q;
  vec3_t              out_p_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr14[i]   = prod13_q[i] + ROUND_HALF;
      step14[i] = neg13_q[i] ? -$signed({2'b00, pr14[i][63:30]})
                             : $signed({2'b00, pr14[i][63:30]});
      sum14[i]  = $signed({{4{o13_q[i][31]}}, o13_q[i]}) + step14[i];
      if (kill13_q) begin
        hit14_d[i] = '0;
      end else if (sum14[i] > 36'sh0_7FFF_FFFF) begin
        hit14_d[i] = 32'h7FFF_FFFF;
      end else if (sum14[i] < -36'sh0_8000_0000) begin
        hit14_d[i] = 32'h8000_0000;
      end else begin
        hit14_d[i] = sum14[i][31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v12_q   <= 1'b0;
      v13_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (ce) begin
      v12_q   <= sq2_v;
      v13_q   <= v12_q;
      out_v_q <= v13_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      o12_q     <= sq2_side.o;
      q12_q     <= sq2_side.q;
      neg12_q   <= sq2_side.neg;
      kill12_q  <= kill12_d;
      t12_q     <= t12_d;
      o13_q     <= o12_q;
      neg13_q   <= neg12_q;
      kill13_q  <= kill12_q;
      prod13_q  <= prod13_d;
      out_hit_q <= !kill13_q;
      out_p_q   <= hit14_d;
    end
  end

  assign ce            = !out_v_q || m_axis_tready;
  assign s_axis_tready = ce;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_p_q;
  assign m_axis_tuser  = out_hit_q;

endmodule

`default_nettype wire
